/* rtl/core/mpps_pkg.sv */
package mpps_pkg;

    localparam int NUM_PROCS     = 16;
    localparam int NUM_LEVELS    = 4;
    localparam int NUM_RESOURCES = 3;
    localparam int TIME_WIDTH    = 16;
    localparam int PID_W         = 4;
    localparam int LVL_W         = 2;
    localparam int QSEL_W        = 3;
    localparam int LEN_W         = 5;

    localparam logic [QSEL_W-1:0] SHARED_Q = 3'd4;
    localparam logic [QSEL_W-1:0] BLOCK_Q0 = 3'd5;
    localparam logic [LEN_W-1:0]  Q_FULL   = 5'd16;
    localparam logic [LVL_W-1:0]  TOP_LVL  = 2'd3;

    localparam logic [2:0] OP_READY   = 3'd0;
    localparam logic [2:0] OP_BLOCK   = 3'd1;
    localparam logic [2:0] OP_UNBLOCK = 3'd2;
    localparam logic [2:0] OP_TICK    = 3'd3;
    localparam logic [2:0] OP_SELECT  = 3'd4;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_BADRS = 2'd2;

    localparam logic [1:0] MODE_HRRN = 2'd0;
    localparam logic [1:0] MODE_MLFQ = 2'd2;

    typedef struct packed {
        logic [2:0]            opcode;
        logic [PID_W-1:0]      proc_id;
        logic [TIME_WIDTH-1:0] burst_len;
        logic [TIME_WIDTH-1:0] remaining_len;
        logic [TIME_WIDTH-1:0] waited_len;
        logic [2:0]            prio_level;
        logic [1:0]            resource_sel;
        logic                  running_valid;
    } sched_in_t;

    typedef struct packed {
        logic [1:0]            status;
        logic [PID_W-1:0]      out_proc;
        logic [LVL_W-1:0]      out_level;
        logic [TIME_WIDTH-1:0] out_remaining;
        logic [TIME_WIDTH-1:0] out_burst;
    } sched_out_t;

    typedef struct packed {
        logic [TIME_WIDTH-1:0] burst;
        logic [TIME_WIDTH-1:0] remain;
        logic [TIME_WIDTH-1:0] waited;
        logic [LVL_W-1:0]      level;
    } entry_t;

    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_CAPTURE,
        CMD_MAKE_READY,
        CMD_BLOCK_PUSH,
        CMD_SET_Q_HEAD,
        CMD_SET_Q_BEST,
        CMD_Q_RD_POS,
        CMD_CAP_PID,
        CMD_SHIFT_RD,
        CMD_SHIFT_WR,
        CMD_Q_DEC,
        CMD_TBL_RD_PID,
        CMD_TBL_RD_ITEM,
        CMD_TICK_CNT,
        CMD_TBL_DEC,
        CMD_SCAN_QRD,
        CMD_SCAN_TRD,
        CMD_SCAN_CMP,
        CMD_WAIT_INC,
        CMD_FINISH_TAKE,
        CMD_RES_OK,
        CMD_RES_ERR
    } dp_cmd_t;

    typedef struct packed {
        logic [2:0] opcode;
        logic [1:0] mode;
        logic       res_bad;
        logic       q_empty;
        logic       shift_more;
        logic       scan_more;
        logic       run_valid;
    } dp_stat_t;

endpackage

/* rtl/core/mpps_ctrl.sv */
module mpps_ctrl
    import mpps_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd,
    output logic     busy
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_TAKE_RD,
        S_TAKE_PID,
        S_SHIFT,
        S_SHIFT_WR,
        S_FIN_RD,
        S_FIN,
        S_TICK_DEC,
        S_WAIT_CHK,
        S_W_TRD,
        S_W_INC,
        S_R_CHK,
        S_R_TRD,
        S_R_CMP
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        cmd        = CMD_NONE;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd        = CMD_CAPTURE;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                priority case (stat.opcode)
                    OP_READY:
                    begin
                        cmd        = CMD_MAKE_READY;
                        state_next = S_FIN;
                    end
                    OP_BLOCK:
                    begin
                        cmd        = stat.res_bad ? CMD_RES_ERR : CMD_BLOCK_PUSH;
                        state_next = stat.res_bad ? S_IDLE : S_FIN;
                    end
                    OP_UNBLOCK:
                    begin
                        if (stat.res_bad || stat.q_empty)
                        begin
                            cmd        = CMD_RES_ERR;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            cmd        = CMD_SET_Q_HEAD;
                            state_next = S_TAKE_RD;
                        end
                    end
                    OP_TICK:
                    begin
                        cmd        = stat.run_valid ? CMD_TBL_RD_ITEM : CMD_TICK_CNT;
                        state_next = stat.run_valid ? S_TICK_DEC : S_WAIT_CHK;
                    end
                    OP_SELECT:
                    begin
                        if (stat.q_empty)
                        begin
                            cmd        = CMD_RES_ERR;
                            state_next = S_IDLE;
                        end
                        else if (stat.mode == MODE_HRRN)
                        begin
                            state_next = S_R_CHK;
                        end
                        else
                        begin
                            cmd        = CMD_SET_Q_HEAD;
                            state_next = S_TAKE_RD;
                        end
                    end
                    default:
                    begin
                        cmd        = CMD_RES_OK;
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_TAKE_RD:
            begin
                cmd        = CMD_Q_RD_POS;
                state_next = S_TAKE_PID;
            end
            S_TAKE_PID:
            begin
                cmd        = CMD_CAP_PID;
                state_next = S_SHIFT;
            end
            S_SHIFT:
            begin
                if (stat.shift_more)
                begin
                    cmd        = CMD_SHIFT_RD;
                    state_next = S_SHIFT_WR;
                end
                else
                begin
                    cmd        = CMD_Q_DEC;
                    state_next = S_FIN_RD;
                end
            end
            S_SHIFT_WR:
            begin
                cmd        = CMD_SHIFT_WR;
                state_next = S_SHIFT;
            end
            S_FIN_RD:
            begin
                cmd        = CMD_TBL_RD_PID;
                state_next = S_FIN;
            end
            S_FIN:
            begin
                cmd        = (stat.opcode == OP_UNBLOCK || stat.opcode == OP_SELECT)
                             ? CMD_FINISH_TAKE : CMD_RES_OK;
                state_next = S_IDLE;
            end
            S_TICK_DEC:
            begin
                cmd        = CMD_TBL_DEC;
                state_next = S_WAIT_CHK;
            end
            S_WAIT_CHK:
            begin
                if (stat.mode == MODE_HRRN && stat.scan_more)
                begin
                    cmd        = CMD_SCAN_QRD;
                    state_next = S_W_TRD;
                end
                else
                begin
                    cmd        = CMD_RES_OK;
                    state_next = S_IDLE;
                end
            end
            S_W_TRD:
            begin
                cmd        = CMD_SCAN_TRD;
                state_next = S_W_INC;
            end
            S_W_INC:
            begin
                cmd        = CMD_WAIT_INC;
                state_next = S_WAIT_CHK;
            end
            S_R_CHK:
            begin
                if (stat.scan_more)
                begin
                    cmd        = CMD_SCAN_QRD;
                    state_next = S_R_TRD;
                end
                else
                begin
                    cmd        = CMD_SET_Q_BEST;
                    state_next = S_TAKE_RD;
                end
            end
            S_R_TRD:
            begin
                cmd        = CMD_SCAN_TRD;
                state_next = S_R_CMP;
            end
            S_R_CMP:
            begin
                cmd        = CMD_SCAN_CMP;
                state_next = S_R_CHK;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

/* rtl/core/mpps_dp.sv */
module mpps_dp
    import mpps_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  dp_cmd_t    cmd,
    input  sched_in_t  item,
    input  logic       cfg_we,
    input  logic [1:0] cfg_wdata,
    output dp_stat_t   stat,
    output sched_out_t result,
    output logic       done
);

    localparam int NQ = 8;

    entry_t             tbl_mem [NUM_PROCS];
    logic [PID_W-1:0]   q_mem   [NQ*NUM_PROCS];
    logic [LEN_W-1:0]   len_reg [NQ];

    entry_t             tbl_rd_reg;
    logic [PID_W-1:0]   q_rd_reg;
    sched_in_t          item_reg;
    logic [1:0]         mode_reg;
    logic [31:0]        tick_count_reg;
    logic [QSEL_W-1:0]  qsel_reg;
    logic [LEN_W-1:0]   pos_reg;
    logic [PID_W-1:0]   pid_reg;
    logic [LEN_W-1:0]   scan_reg;
    logic [LEN_W-1:0]   best_reg;
    logic [TIME_WIDTH-1:0] bw_reg;
    logic [TIME_WIDTH:0]   bs_reg;
    sched_out_t         result_reg;
    logic               done_reg;

    logic [QSEL_W-1:0]  pick_q;
    logic               lvl_found;
    logic [QSEL_W-1:0]  blk_q;
    logic               res_bad;
    logic [LVL_W-1:0]   in_level;
    logic [TIME_WIDTH:0]   cur_s;
    logic [2*TIME_WIDTH:0] lhs, rhs;
    entry_t             mod_entry;

    logic               push_en;
    logic [QSEL_W-1:0]  push_q;
    logic [PID_W-1:0]   push_pid;
    logic               tbl_we;
    logic [PID_W-1:0]   tbl_waddr;
    entry_t             tbl_wdata;
    logic               tbl_re;
    logic [PID_W-1:0]   tbl_raddr;
    logic               q_re;
    logic [QSEL_W+PID_W-1:0] q_raddr;
    logic [LEN_W-1:0]   pos_inc;

    assign res_bad  = (item_reg.resource_sel >= 2'(NUM_RESOURCES));
    assign blk_q    = BLOCK_Q0 + QSEL_W'(item_reg.resource_sel);
    assign in_level = (item_reg.prio_level > 3'(TOP_LVL)) ? TOP_LVL
                                                          : item_reg.prio_level[LVL_W-1:0];
    assign pos_inc  = pos_reg + LEN_W'(1);

    always_comb
    begin
        pick_q    = SHARED_Q;
        lvl_found = 1'b0;
        for (int l = NUM_LEVELS - 1; l >= 0; l--)
        begin
            if (len_reg[l] != '0)
            begin
                pick_q    = QSEL_W'(l);
                lvl_found = 1'b1;
            end
        end
    end

    always_comb
    begin
        stat.opcode     = item_reg.opcode;
        stat.mode       = mode_reg;
        stat.res_bad    = res_bad;
        stat.run_valid  = item_reg.running_valid;
        stat.shift_more = (pos_inc < len_reg[qsel_reg]);
        stat.scan_more  = (scan_reg < len_reg[SHARED_Q]);
        if (item_reg.opcode == OP_UNBLOCK)
        begin
            stat.q_empty = (len_reg[blk_q] == '0);
        end
        else if (mode_reg == MODE_MLFQ)
        begin
            stat.q_empty = !lvl_found;
        end
        else
        begin
            stat.q_empty = (len_reg[SHARED_Q] == '0);
        end
    end

    assign cur_s = (tbl_rd_reg.burst == '0) ? (TIME_WIDTH+1)'(1)
                                            : {1'b0, tbl_rd_reg.burst};
    assign lhs   = tbl_rd_reg.waited * bs_reg;
    assign rhs   = bw_reg * cur_s;

    always_comb
    begin
        mod_entry = tbl_rd_reg;
        if (item_reg.opcode == OP_SELECT && mode_reg == MODE_MLFQ)
        begin
            mod_entry.level = qsel_reg[LVL_W-1:0];
        end
        if (item_reg.opcode == OP_SELECT && mode_reg == MODE_HRRN)
        begin
            mod_entry.waited = '0;
        end
    end

    always_comb
    begin
        push_en   = 1'b0;
        push_q    = SHARED_Q;
        push_pid  = item_reg.proc_id;
        tbl_we    = 1'b0;
        tbl_waddr = item_reg.proc_id;
        tbl_wdata = tbl_rd_reg;
        tbl_re    = 1'b0;
        tbl_raddr = pid_reg;
        q_re      = 1'b0;
        q_raddr   = {qsel_reg, pos_reg[PID_W-1:0]};
        unique case (cmd)
            CMD_MAKE_READY:
            begin
                tbl_we    = 1'b1;
                tbl_wdata = '{burst: item_reg.burst_len, remain: item_reg.remaining_len,
                              waited: item_reg.waited_len, level: in_level};
                push_en   = 1'b1;
                push_q    = (mode_reg == MODE_MLFQ) ? QSEL_W'(in_level) : SHARED_Q;
            end
            CMD_BLOCK_PUSH:
            begin
                push_en = 1'b1;
                push_q  = blk_q;
            end
            CMD_Q_RD_POS:
            begin
                q_re = 1'b1;
            end
            CMD_SHIFT_RD:
            begin
                q_re    = 1'b1;
                q_raddr = {qsel_reg, pos_inc[PID_W-1:0]};
            end
            CMD_SCAN_QRD:
            begin
                q_re    = 1'b1;
                q_raddr = {SHARED_Q, scan_reg[PID_W-1:0]};
            end
            CMD_TBL_RD_PID:
            begin
                tbl_re = 1'b1;
            end
            CMD_TBL_RD_ITEM:
            begin
                tbl_re    = 1'b1;
                tbl_raddr = item_reg.proc_id;
            end
            CMD_SCAN_TRD:
            begin
                tbl_re    = 1'b1;
                tbl_raddr = q_rd_reg;
            end
            CMD_TBL_DEC:
            begin
                tbl_we = 1'b1;
                if (tbl_rd_reg.remain != '0)
                begin
                    tbl_wdata.remain = tbl_rd_reg.remain - TIME_WIDTH'(1);
                end
            end
            CMD_WAIT_INC:
            begin
                tbl_we    = 1'b1;
                tbl_waddr = q_rd_reg;
                if (tbl_rd_reg.waited != '1)
                begin
                    tbl_wdata.waited = tbl_rd_reg.waited + TIME_WIDTH'(1);
                end
            end
            CMD_FINISH_TAKE:
            begin
                tbl_we    = 1'b1;
                tbl_waddr = pid_reg;
                tbl_wdata = mod_entry;
                push_pid  = pid_reg;
                push_en   = (item_reg.opcode == OP_UNBLOCK);
                push_q    = (mode_reg == MODE_MLFQ) ? QSEL_W'(tbl_rd_reg.level) : SHARED_Q;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (tbl_we)
        begin
            tbl_mem[tbl_waddr] <= tbl_wdata;
        end
        if (tbl_re)
        begin
            tbl_rd_reg <= tbl_mem[tbl_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_en && len_reg[push_q] < Q_FULL)
        begin
            q_mem[{push_q, len_reg[push_q][PID_W-1:0]}] <= push_pid;
        end
        else if (cmd == CMD_SHIFT_WR)
        begin
            q_mem[{qsel_reg, pos_reg[PID_W-1:0]}] <= q_rd_reg;
        end
        if (q_re)
        begin
            q_rd_reg <= q_mem[q_raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd == CMD_CAPTURE)
        begin
            item_reg <= item;
        end
        if (cmd == CMD_CAP_PID)
        begin
            pid_reg <= q_rd_reg;
        end
        if (cmd == CMD_SCAN_CMP && (scan_reg == '0 || lhs > rhs))
        begin
            best_reg <= scan_reg;
            bw_reg   <= tbl_rd_reg.waited;
            bs_reg   <= cur_s;
        end
        if (cmd == CMD_SET_Q_HEAD)
        begin
            if (item_reg.opcode == OP_UNBLOCK)
            begin
                qsel_reg <= blk_q;
            end
            else
            begin
                qsel_reg <= (mode_reg == MODE_MLFQ) ? pick_q : SHARED_Q;
            end
            pos_reg  <= '0;
        end
        else if (cmd == CMD_SET_Q_BEST)
        begin
            qsel_reg <= SHARED_Q;
            pos_reg  <= best_reg;
        end
        else if (cmd == CMD_SHIFT_WR)
        begin
            pos_reg <= pos_inc;
        end
        if (cmd == CMD_FINISH_TAKE)
        begin
            result_reg <= '{status: ST_OK, out_proc: pid_reg, out_level: mod_entry.level,
                            out_remaining: mod_entry.remain, out_burst: mod_entry.burst};
        end
        else if (cmd == CMD_RES_ERR)
        begin
            result_reg <= '{status: (res_bad && item_reg.opcode != OP_SELECT) ? ST_BADRS
                                                                             : ST_EMPTY,
                            out_proc: '0, out_level: '0, out_remaining: '0, out_burst: '0};
        end
        else if (cmd == CMD_RES_OK)
        begin
            result_reg <= '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_HRRN;
            tick_count_reg <= '0;
            scan_reg       <= '0;
            done_reg       <= 1'b0;
            for (int q = 0; q < NQ; q++)
            begin
                len_reg[q] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                mode_reg <= cfg_wdata;
            end
            if (cmd == CMD_TICK_CNT || cmd == CMD_TBL_RD_ITEM)
            begin
                tick_count_reg <= tick_count_reg + 32'd1;
            end
            if (cmd == CMD_CAPTURE)
            begin
                scan_reg <= '0;
            end
            else if (cmd == CMD_SCAN_CMP || cmd == CMD_WAIT_INC)
            begin
                scan_reg <= scan_reg + LEN_W'(1);
            end
            if (push_en && len_reg[push_q] < Q_FULL)
            begin
                len_reg[push_q] <= len_reg[push_q] + LEN_W'(1);
            end
            else if (cmd == CMD_Q_DEC)
            begin
                len_reg[qsel_reg] <= len_reg[qsel_reg] - LEN_W'(1);
            end
            done_reg <= (cmd == CMD_FINISH_TAKE || cmd == CMD_RES_ERR
                         || cmd == CMD_RES_OK);
        end
    end

    assign result = result_reg;
    assign done   = done_reg;

endmodule

/* rtl/core/multi_policy_process_scheduler_unit.sv */
// Task scheduler over a 16-entry process table and eight FIFO queues.
// Channels: an item (sched_in_t) is taken on a clock edge where start is
// high and busy is low. Its one result (sched_out_t) appears on result,
// marked by done, high for exactly one cycle; the receiver cannot stall it.
// Mode register: cfg_we writes cfg_wdata at once; write only while idle.
// Steps: make ready and block push their entry, then end; errors and
// unused opcodes end at dispatch. Tick decrements the running process's
// remaining time if one runs, then in ratio mode raises the waited time of
// each shared-queue entry in turn. Round robin / feedback select and unblock
// take the queue head, then shift the rest down one slot at a time, each
// slot read and then written back. Ratio select first scans the entries
// with one comparator, then the winner is removed the same way.
// A new item may start in the cycle done is high.
// Reset empties all queues, clears the tick counter and sets ratio mode;
// the process table and queue slots hold no reset value.
module multi_policy_process_scheduler_unit
    import mpps_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  sched_in_t  item,
    output sched_out_t result,
    output logic       done,
    input  logic       cfg_we,
    input  logic [1:0] cfg_wdata
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    mpps_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    mpps_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .item      (item),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .stat      (stat),
        .result    (result),
        .done      (done)
    );

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("two results in a row");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.status == ST_OK || result.status == ST_EMPTY
                  || result.status == ST_BADRS))
        else $error("bad status code");

endmodule

/* bench/multi_policy_process_scheduler_unit_tb.sv */
`timescale 1ns / 1ps

module multi_policy_process_scheduler_unit_tb;
    import mpps_pkg::*;

    class sched_scoreboard;
        logic [TIME_WIDTH-1:0] burst [NUM_PROCS];
        logic [TIME_WIDTH-1:0] remain [NUM_PROCS];
        logic [TIME_WIDTH-1:0] waited [NUM_PROCS];
        logic [2:0] level [NUM_PROCS];
        bit written [NUM_PROCS];
        int unsigned qs [8][$];
        logic [1:0] mode;
        logic [31:0] ticks;
        sched_out_t pending [$];
        int errors;

        function new();
            mode = MODE_HRRN;
            ticks = 0;
            errors = 0;
            for (int i = 0; i < NUM_PROCS; i++)
            begin
                burst[i] = 0; remain[i] = 0; waited[i] = 0; level[i] = 0; written[i] = 0;
            end
        endfunction

        function void push_q(int q, int pid);
            if (qs[q].size() < NUM_PROCS)
                qs[q].push_back(pid);
        endfunction

        function void ready_proc(int pid);
            if (level[pid] > TOP_LVL)
                level[pid] = TOP_LVL;
            if (mode == MODE_MLFQ)
                push_q(level[pid], pid);
            else
                push_q(SHARED_Q, pid);
        endfunction

        function sched_out_t report(int pid);
            sched_out_t r;
            r.status = ST_OK;
            r.out_proc = PID_W'(pid);
            r.out_level = level[pid][1:0];
            r.out_remaining = remain[pid];
            r.out_burst = burst[pid];
            return r;
        endfunction

        function void note_item(sched_in_t it);
            sched_out_t r;
            int pid;
            int best;
            longint bw, bs, s, w;
            r = '0;
            pid = it.proc_id;
            case (it.opcode)
                OP_READY:
                begin
                    burst[pid] = it.burst_len;
                    remain[pid] = it.remaining_len;
                    waited[pid] = it.waited_len;
                    level[pid] = it.prio_level;
                    written[pid] = 1;
                    ready_proc(pid);
                end
                OP_BLOCK:
                begin
                    if (it.resource_sel >= NUM_RESOURCES)
                        r.status = ST_BADRS;
                    else
                        push_q(BLOCK_Q0 + it.resource_sel, pid);
                end
                OP_UNBLOCK:
                begin
                    if (it.resource_sel >= NUM_RESOURCES)
                        r.status = ST_BADRS;
                    else if (qs[BLOCK_Q0 + it.resource_sel].size() == 0)
                        r.status = ST_EMPTY;
                    else
                    begin
                        pid = qs[BLOCK_Q0 + it.resource_sel].pop_front();
                        ready_proc(pid);
                        r = report(pid);
                    end
                end
                OP_TICK:
                begin
                    ticks++;
                    if (it.running_valid && remain[pid] > 0)
                        remain[pid]--;
                    if (mode == MODE_HRRN)
                        foreach (qs[SHARED_Q][i])
                            if (waited[qs[SHARED_Q][i]] != '1)
                                waited[qs[SHARED_Q][i]]++;
                end
                OP_SELECT:
                begin
                    if (mode == MODE_MLFQ)
                    begin
                        r.status = ST_EMPTY;
                        for (int lv = 0; lv < NUM_LEVELS; lv++)
                            if (qs[lv].size() != 0)
                            begin
                                pid = qs[lv].pop_front();
                                level[pid] = 3'(lv);
                                r = report(pid);
                                break;
                            end
                    end
                    else if (qs[SHARED_Q].size() == 0)
                        r.status = ST_EMPTY;
                    else if (mode == MODE_HRRN)
                    begin
                        best = 0; bw = 0; bs = 1;
                        foreach (qs[SHARED_Q][i])
                        begin
                            s = burst[qs[SHARED_Q][i]] == 0 ? 1 : burst[qs[SHARED_Q][i]];
                            w = waited[qs[SHARED_Q][i]];
                            if (i == 0 || w * bs > bw * s)
                            begin
                                best = i; bw = w; bs = s;
                            end
                        end
                        pid = qs[SHARED_Q][best];
                        qs[SHARED_Q].delete(best);
                        waited[pid] = 0;
                        r = report(pid);
                    end
                    else
                        r = report(qs[SHARED_Q].pop_front());
                end
                default: ;
            endcase
            pending.push_back(r);
        endfunction

        function void check_result(sched_out_t got);
            sched_out_t exp;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result %h", $realtime, got);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got.status !== exp.status || got.out_proc !== exp.out_proc ||
                got.out_level !== exp.out_level || got.out_remaining !== exp.out_remaining ||
                got.out_burst !== exp.out_burst)
            begin
                $display("%0t: mismatch expected %h actual %h", $realtime, exp, got);
                errors++;
            end
        endfunction
    endclass

    logic clk, rst_n, start, busy, done, cfg_we;
    logic [1:0] cfg_wdata;
    sched_in_t item;
    sched_out_t result;
    sched_scoreboard sb;
    int unsigned cycles;

    multi_policy_process_scheduler_unit dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .item(item),
        .result(result), .done(done), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    initial
    begin
        clk = 0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        sb = new();
        cycles = 0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n && done)
            sb.check_result(result);
        if (cycles > 2000000)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic send_item(sched_in_t it);
        int gap;
        gap = $urandom_range(0, 10);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        item <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_item(it);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_mode(logic [1:0] m);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= m;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.mode = m;
    endtask

    function automatic sched_in_t make_item(logic [2:0] op, logic [3:0] pid, logic [1:0] rs);
        sched_in_t it;
        it = '0;
        it.prio_level = 3'($urandom);
        it.running_valid = 1'($urandom);
        it.burst_len = 16'($urandom);
        it.remaining_len = 16'($urandom);
        it.waited_len = 16'($urandom);
        it.opcode = op;
        it.proc_id = pid;
        it.resource_sel = rs;
        return it;
    endfunction

    // Only processes that were made ready may be blocked, so unblock never
    // returns a never-written entry.
    function automatic sched_in_t rand_item();
        sched_in_t it;
        int r;
        logic [3:0] pid;
        r = $urandom_range(0, 99);
        pid = 4'($urandom_range(0, NUM_PROCS - 1));
        if (r < 30)
            it = make_item(OP_READY, pid, 2'($urandom));
        else if (r < 42)
            it = make_item(sb.written[pid] ? OP_BLOCK : OP_READY, pid, 2'($urandom));
        else if (r < 55)
            it = make_item(OP_UNBLOCK, pid, 2'($urandom));
        else if (r < 70)
            it = make_item(OP_TICK, pid, 2'($urandom));
        else if (r < 97)
            it = make_item(OP_SELECT, pid, 2'($urandom));
        else
            it = make_item(3'($urandom_range(5, 7)), pid, 2'($urandom));
        if ($urandom_range(0, 3) == 0)
            it.burst_len = 16'($urandom_range(0, 3));
        if ($urandom_range(0, 5) == 0)
            it.waited_len = 16'hFFFF - 16'($urandom_range(0, 2));
        return it;
    endfunction

    initial
    begin
        sched_in_t it;
        logic [1:0] modes [4];
        rst_n = 0;
        start = 0;
        cfg_we = 0;
        cfg_wdata = 0;
        item = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed
        send_item(make_item(OP_SELECT, 4'd0, 2'd0));
        send_item(make_item(OP_UNBLOCK, 4'd0, 2'd0));
        send_item(make_item(OP_UNBLOCK, 4'd0, 2'd3));
        send_item(make_item(OP_BLOCK, 4'd0, 2'd3));
        it = make_item(OP_READY, 4'd0, 2'd0);
        it.burst_len = 0; it.remaining_len = 0; it.waited_len = 16'hFFFF; it.prio_level = 7;
        send_item(it);
        it = make_item(OP_READY, 4'd15, 2'd0);
        it.burst_len = 16'hFFFF; it.remaining_len = 16'hFFFF; it.waited_len = 0;
        it.prio_level = 0;
        send_item(it);
        it = make_item(OP_TICK, 4'd0, 2'd0); it.running_valid = 1;
        send_item(it);
        send_item(it);
        it = make_item(OP_TICK, 4'd15, 2'd0); it.running_valid = 1;
        send_item(it);
        send_item(make_item(OP_BLOCK, 4'd15, 2'd2));
        send_item(make_item(OP_SELECT, 4'd0, 2'd0));
        send_item(make_item(OP_SELECT, 4'd0, 2'd0));
        send_item(make_item(OP_UNBLOCK, 4'd0, 2'd2));
        send_item(make_item(3'd5, 4'd0, 2'd0));
        send_item(make_item(3'd7, 4'd0, 2'd0));
        for (int i = 0; i < 17; i++)
            send_item(make_item(OP_READY, i[3:0], 2'd0));
        drain();

        modes[0] = 2'd0; modes[1] = 2'd1; modes[2] = 2'd2; modes[3] = 2'd3;
        for (int ph = 0; ph < 8; ph++)
        begin
            write_mode(ph < 4 ? modes[ph] : 2'($urandom));
            for (int n = 0; n < 75; n++)
                send_item(rand_item());
        end

        drain();
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
